FILE: hw/rtl/lzss_ti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LZSS tree insert package
// Constants, sequencer states and the text store write bundle shared by the
// match finder modules.
// ---------------------------------------------------------------------------
package lzss_ti_pkg;

  // Ring and match geometry
  localparam int RING_SIZE    = 4096;
  localparam int MAX_MATCH    = 18;
  localparam int NODE_W       = 13;
  localparam int POS_W        = 12;
  localparam int LEN_W        = 5;
  localparam int TEXT_DEPTH   = RING_SIZE + MAX_MATCH;
  localparam int LEFT_DEPTH   = RING_SIZE + 1;
  localparam int RIGHT_DEPTH  = RING_SIZE + 257;
  localparam int PARENT_DEPTH = RING_SIZE + 1;
  localparam int VISIT_LIMIT  = RING_SIZE + 1;

  localparam logic [NODE_W-1:0] NIL_NODE  = NODE_W'(RING_SIZE);
  localparam logic [NODE_W-1:0] ROOT_BASE = NODE_W'(RING_SIZE + 1);

  // Item operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT,
    ST_LINK,
    ST_NEXT,
    ST_CMP,
    ST_CMPW,
    ST_EVAL,
    ST_REP0,
    ST_REP1,
    ST_REP2,
    ST_REP3,
    ST_REP4,
    ST_DONE
  } state_t;

  // Write request to the text store
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [7:0]        data;
  } text_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lzss_ti_text.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LZSS text store
// Byte memory with one write port and two registered read ports, used to
// fetch both strings of a comparison in the same cycle.
// ---------------------------------------------------------------------------
module lzss_ti_text (
  input  wire logic                            clk,
  input  wire lzss_ti_pkg::text_wr_t           wr,
  input  wire logic [lzss_ti_pkg::NODE_W-1:0]  raddr_a,
  input  wire logic [lzss_ti_pkg::NODE_W-1:0]  raddr_b,
  output logic      [7:0]                      rdata_a,
  output logic      [7:0]                      rdata_b
);

  logic [7:0] mem [lzss_ti_pkg::TEXT_DEPTH];

  // Write port; addresses past the end of the store are dropped.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr < lzss_ti_pkg::NODE_W'(lzss_ti_pkg::TEXT_DEPTH))) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lzss_tree_insert_match_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A write item is stored when accepted; the block is ready again on the
// next cycle. An insert reads the root, then for each visited node fetches
// the link, compares bytes one at a time on the shared byte comparator and
// evaluates the match; a full match that replaces a node adds a replacement
// sequence, and a result still waiting in the output register holds the
// last step. After reset a clearing pass sets all tree links to nil; no
// item is accepted until it ends. The result is held until transferred.
// ---------------------------------------------------------------------------
// LZSS binary tree insert and match finder
// Stores text bytes, inserts strings into per-byte search trees and reports
// the longest match found on the walk, using one sequencer and one comparator.
// ---------------------------------------------------------------------------
module lzss_tree_insert_match_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [0:0]  opcode,
  input  wire logic [12:0] buffer_address,
  input  wire logic [7:0]  data_byte,
  input  wire logic [11:0] insert_position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      match_position,
  output logic [4:0]       match_length
);

  localparam int NW = lzss_ti_pkg::NODE_W;
  localparam int PW = lzss_ti_pkg::POS_W;
  localparam int LW = lzss_ti_pkg::LEN_W;

  lzss_ti_pkg::state_t state, state_next;

  // Link memories
  logic [NW-1:0] left_mem   [lzss_ti_pkg::LEFT_DEPTH];
  logic [NW-1:0] right_mem  [lzss_ti_pkg::RIGHT_DEPTH];
  logic [NW-1:0] parent_mem [lzss_ti_pkg::PARENT_DEPTH];

  logic          l_we, r_we, p_we;
  logic [NW-1:0] l_wa, r_wa, p_wa, l_wd, r_wd, p_wd;
  logic [NW-1:0] l_ra, r_ra, p_ra;
  logic [NW-1:0] l_rdata, r_rdata, p_rdata;
  logic          l_oob, r_oob;

  // Walk registers
  logic [PW-1:0] ins_pos;
  logic [NW-1:0] node;
  logic [NW-1:0] visits;
  logic [LW-1:0] k_cnt;
  logic          diff_ge;
  logic [NW-1:0] q_node, lc_node, rc_node;
  logic [NW-1:0] clr_cnt;
  logic [PW-1:0] best_position;
  logic [LW-1:0] best_length;

  // Text store
  lzss_ti_pkg::text_wr_t text_wr;
  logic [NW-1:0]         t_ra_a, t_ra_b;
  logic [7:0]            t_rd_a, t_rd_b;

  logic [NW-1:0] ins_node;
  logic [NW-1:0] next_node;
  logic          accept;

  assign ins_node  = {1'b0, ins_pos};
  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == lzss_ti_pkg::ST_IDLE);
  assign next_node = diff_ge ? (r_oob ? lzss_ti_pkg::NIL_NODE : r_rdata)
                             : (l_oob ? lzss_ti_pkg::NIL_NODE : l_rdata);

  lzss_ti_text u_text (
    .clk     (clk),
    .wr      (text_wr),
    .raddr_a (t_ra_a),
    .raddr_b (t_ra_b),
    .rdata_a (t_rd_a),
    .rdata_b (t_rd_b)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzss_ti_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port control.
  always_comb begin
    state_next   = state;
    text_wr.en   = 1'b0;
    text_wr.addr = buffer_address;
    text_wr.data = data_byte;
    t_ra_a       = {1'b0, insert_position};
    t_ra_b       = node + NW'(k_cnt);
    l_we = 1'b0; l_wa = ins_node; l_wd = lzss_ti_pkg::NIL_NODE;
    r_we = 1'b0; r_wa = ins_node; r_wd = lzss_ti_pkg::NIL_NODE;
    p_we = 1'b0; p_wa = ins_node; p_wd = lzss_ti_pkg::NIL_NODE;
    l_ra = node; r_ra = node; p_ra = node;
    unique case (state)
      lzss_ti_pkg::ST_CLEAR: begin
        l_wa = clr_cnt; r_wa = clr_cnt; p_wa = clr_cnt;
        l_we = (clr_cnt < NW'(lzss_ti_pkg::LEFT_DEPTH));
        r_we = 1'b1;
        p_we = (clr_cnt < NW'(lzss_ti_pkg::PARENT_DEPTH));
        if (clr_cnt == NW'(lzss_ti_pkg::RIGHT_DEPTH - 1)) begin
          state_next = lzss_ti_pkg::ST_IDLE;
        end
      end
      lzss_ti_pkg::ST_IDLE: begin
        if (accept && (opcode == lzss_ti_pkg::OP_WRITE)) begin
          text_wr.en = 1'b1;
        end else if (accept) begin
          l_we = 1'b1; l_wa = {1'b0, insert_position};
          r_we = 1'b1; r_wa = {1'b0, insert_position};
          state_next = lzss_ti_pkg::ST_ROOT;
        end
      end
      lzss_ti_pkg::ST_ROOT: begin
        state_next = lzss_ti_pkg::ST_LINK;
      end
      lzss_ti_pkg::ST_LINK: begin
        state_next = lzss_ti_pkg::ST_NEXT;
      end
      lzss_ti_pkg::ST_NEXT: begin
        if (next_node == lzss_ti_pkg::NIL_NODE) begin
          // Attach the new string as a leaf.
          r_we = diff_ge; r_wa = node; r_wd = ins_node;
          l_we = !diff_ge && (node < NW'(lzss_ti_pkg::LEFT_DEPTH));
          l_wa = node; l_wd = ins_node;
          p_we = 1'b1; p_wd = node;
          state_next = lzss_ti_pkg::ST_DONE;
        end else if ((next_node >= NW'(lzss_ti_pkg::RING_SIZE)) ||
                     (visits >= NW'(lzss_ti_pkg::VISIT_LIMIT))) begin
          state_next = lzss_ti_pkg::ST_DONE;
        end else begin
          state_next = lzss_ti_pkg::ST_CMP;
        end
      end
      lzss_ti_pkg::ST_CMP: begin
        t_ra_a     = ins_node + NW'(k_cnt);
        state_next = lzss_ti_pkg::ST_CMPW;
      end
      lzss_ti_pkg::ST_CMPW: begin
        if ((t_rd_a != t_rd_b) || (k_cnt == LW'(lzss_ti_pkg::MAX_MATCH - 1))) begin
          state_next = lzss_ti_pkg::ST_EVAL;
        end else begin
          state_next = lzss_ti_pkg::ST_CMP;
        end
      end
      lzss_ti_pkg::ST_EVAL: begin
        if ((k_cnt > best_length) && (k_cnt >= LW'(lzss_ti_pkg::MAX_MATCH))) begin
          state_next = lzss_ti_pkg::ST_REP0;
        end else begin
          state_next = lzss_ti_pkg::ST_LINK;
        end
      end
      lzss_ti_pkg::ST_REP0: begin
        state_next = lzss_ti_pkg::ST_REP1;
      end
      lzss_ti_pkg::ST_REP1: begin
        // The new node inherits the parent and children of the matched node.
        p_we = 1'b1; p_wd = p_rdata;
        l_we = 1'b1; l_wd = l_rdata;
        r_we = 1'b1; r_wd = r_rdata;
        state_next = lzss_ti_pkg::ST_REP2;
      end
      lzss_ti_pkg::ST_REP2: begin
        p_we = (lc_node < NW'(lzss_ti_pkg::PARENT_DEPTH));
        p_wa = lc_node; p_wd = ins_node;
        state_next = lzss_ti_pkg::ST_REP3;
      end
      lzss_ti_pkg::ST_REP3: begin
        p_we = (rc_node < NW'(lzss_ti_pkg::PARENT_DEPTH));
        p_wa = rc_node; p_wd = ins_node;
        r_ra = q_node;
        state_next = lzss_ti_pkg::ST_REP4;
      end
      lzss_ti_pkg::ST_REP4: begin
        // Hook the new node under the old parent and detach the old node.
        if (!r_oob && (r_rdata == node)) begin
          r_we = 1'b1; r_wa = q_node; r_wd = ins_node;
        end else begin
          l_we = (q_node < NW'(lzss_ti_pkg::LEFT_DEPTH));
          l_wa = q_node; l_wd = ins_node;
        end
        p_we = 1'b1; p_wa = node; p_wd = lzss_ti_pkg::NIL_NODE;
        state_next = lzss_ti_pkg::ST_DONE;
      end
      lzss_ti_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = lzss_ti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lzss_ti_pkg::ST_CLEAR;
      end
    endcase
  end

  // Link memory ports.
  always_ff @(posedge clk) begin
    if (l_we) begin
      left_mem[l_wa] <= l_wd;
    end
    if (r_we && (r_wa < NW'(lzss_ti_pkg::RIGHT_DEPTH))) begin
      right_mem[r_wa] <= r_wd;
    end
    if (p_we) begin
      parent_mem[p_wa] <= p_wd;
    end
    l_rdata <= left_mem[l_ra];
    r_rdata <= right_mem[r_ra];
    p_rdata <= parent_mem[p_ra];
    l_oob   <= (l_ra >= NW'(lzss_ti_pkg::LEFT_DEPTH));
    r_oob   <= (r_ra >= NW'(lzss_ti_pkg::RIGHT_DEPTH));
  end

  // Walk datapath and shared byte comparator.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt       <= '0;
      best_position <= '0;
      best_length   <= '0;
      visits        <= '0;
      k_cnt         <= '0;
      diff_ge       <= 1'b1;
    end else begin
      unique case (state)
        lzss_ti_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + NW'(1);
        end
        lzss_ti_pkg::ST_IDLE: begin
          if (accept && (opcode == lzss_ti_pkg::OP_INSERT)) begin
            ins_pos     <= insert_position;
            best_length <= '0;
            visits      <= '0;
            diff_ge     <= 1'b1;
          end
        end
        lzss_ti_pkg::ST_ROOT: begin
          node <= lzss_ti_pkg::ROOT_BASE + NW'(t_rd_a);
        end
        lzss_ti_pkg::ST_NEXT: begin
          node   <= next_node;
          visits <= visits + NW'(1);
          k_cnt  <= LW'(1);
        end
        lzss_ti_pkg::ST_CMPW: begin
          if (t_rd_a != t_rd_b) begin
            diff_ge <= (t_rd_a > t_rd_b);
          end else begin
            diff_ge <= 1'b1;
            k_cnt   <= k_cnt + LW'(1);
          end
        end
        lzss_ti_pkg::ST_EVAL: begin
          if (k_cnt > best_length) begin
            best_position <= node[PW-1:0];
            best_length   <= k_cnt;
          end
        end
        lzss_ti_pkg::ST_REP1: begin
          q_node  <= p_rdata;
          lc_node <= l_rdata;
          rc_node <= r_rdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == lzss_ti_pkg::ST_DONE) && (!out_valid || out_ready)) begin
      out_valid      <= 1'b1;
      match_position <= best_position;
      match_length   <= best_length;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Checks
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    best_length <= LW'(lzss_ti_pkg::MAX_MATCH))
    else $error("best length beyond maximum match");

  a_cmp_node: assert property (@(posedge clk) disable iff (rst)
    (state == lzss_ti_pkg::ST_CMP) |-> (node < NW'(lzss_ti_pkg::RING_SIZE)))
    else $error("comparison on a root or nil node");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == lzss_ti_pkg::ST_EVAL) |->
      ((k_cnt >= LW'(1)) && (k_cnt <= LW'(lzss_ti_pkg::MAX_MATCH))))
    else $error("match length count out of range");

  a_visit_bound: assert property (@(posedge clk) disable iff (rst)
    visits <= NW'(lzss_ti_pkg::VISIT_LIMIT + 1))
    else $error("walk visited too many nodes");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    ((state == lzss_ti_pkg::ST_DONE) && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished insert gave no result");

endmodule

`default_nettype wire
